// ===== hdl/fixed_point_q24_8_alu_defines.svh =====
// Assertion macros for the fixed-point ALU
`ifndef FIXED_POINT_Q24_8_ALU_DEFINES_SVH
`define FIXED_POINT_Q24_8_ALU_DEFINES_SVH
`ifndef SYNTHESIS
`define FPA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FPA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define FPA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/fpa_pkg.sv =====
`default_nettype none
package fpa_pkg;
  localparam int OP_BITS = 4;
  typedef logic [OP_BITS-1:0] op_t;
  localparam op_t OP_ADD = 4'd0;
  localparam op_t OP_SUB = 4'd1;
  localparam op_t OP_MUL = 4'd2;
  localparam op_t OP_DIV = 4'd3;
  localparam op_t OP_GT = 4'd4;
  localparam op_t OP_LT = 4'd5;
  localparam op_t OP_GE = 4'd6;
  localparam op_t OP_LE = 4'd7;
  localparam op_t OP_EQ = 4'd8;
  localparam op_t OP_NE = 4'd9;
  localparam op_t OP_MIN = 4'd10;
  localparam op_t OP_MAX = 4'd11;
  localparam op_t OP_INC = 4'd12;
  localparam op_t OP_DEC = 4'd13;
  localparam op_t OP_TO_INT = 4'd14;
  localparam op_t OP_FROM_INT = 4'd15;
  localparam int IO_BITS = 32;
endpackage
`default_nettype wire

// ===== hdl/fpa_if.sv =====
`default_nettype none
// Valid/ready channel carrying an ALU operation or result
interface fpa_in_if
  import fpa_pkg::*;
  ();
  logic valid;
  logic ready;
  op_t op;
  logic signed [IO_BITS-1:0] operand_a;
  logic signed [IO_BITS-1:0] operand_b;
  modport source (output valid, op, operand_a, operand_b, input ready);
  modport sink (input valid, op, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if
  import fpa_pkg::*;
  ();
  logic valid;
  logic ready;
  logic signed [IO_BITS-1:0] result_value;
  logic compare_true;
  logic divide_error;
  modport source (output valid, result_value, compare_true, divide_error, input ready);
  modport sink (input valid, result_value, compare_true, divide_error, output ready);
endinterface
`default_nettype wire

// ===== hdl/fpa_div_stage.sv =====
`default_nettype none
// One restoring-division step per stage: shift in one numerator bit, try subtract.
module fpa_div_stage
  import fpa_pkg::*;
  #(parameter int NB = 40, parameter int DB = 32)
  (
    input wire logic [NB-1:0] num_in,
    input wire logic [DB:0] rem_in,
    input wire logic [DB-1:0] den,
    output logic [NB-1:0] num_out,
    output logic [DB:0] rem_out
  );
  logic [DB+1:0] shifted;
  logic [DB+1:0] diff;
  always_comb begin
    shifted = {rem_in, num_in[NB-1]};
    diff = shifted - {2'b00, den};
    if (!diff[DB+1]) begin
      rem_out = diff[DB:0];
      num_out = {num_in[NB-2:0], 1'b1};
    end else begin
      rem_out = shifted[DB:0];
      num_out = {num_in[NB-2:0], 1'b0};
    end
  end
endmodule
`default_nettype wire

// ===== hdl/fixed_point_q24_8_alu.sv =====
// Path: operand register, divide stages (one quotient bit each), then output register.
// Throughput: one transaction per cycle unless stalled; the divider is unrolled.
// Stall: the whole pipeline holds while the output is valid and not taken.
// Reset: rst (synchronous) clears all stage valid bits; payload is not reset.
`default_nettype none
`include "fixed_point_q24_8_alu_defines.svh"
module fixed_point_q24_8_alu
  import fpa_pkg::*;
  #(
    parameter int FRAC_BITS = 8,
    parameter int WORD_BITS = 32
  )
  (
    input wire logic clk,
    input wire logic rst,
    fpa_in_if.sink in_ch,
    fpa_out_if.source out_ch
  );
  localparam int W = WORD_BITS;
  localparam int NB = W + FRAC_BITS;       // numerator bits of the divide
  localparam int NS = NB;                  // divide stages
  localparam int PB = 2 * W;               // product bits

  typedef struct packed {
    op_t op;
    logic neg;
    logic derr;
    logic cmp;
    logic [W-1:0] simple;
  } ctl_t;

  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // ---- stage 0 : decode operands, simple ops, magnitudes ----
  logic signed [W-1:0] a, b;
  logic [W-1:0] ma, mb;
  ctl_t c0;
  logic lt, gt;
  always_comb begin
    a = in_ch.operand_a[W-1:0];
    b = in_ch.operand_b[W-1:0];
    ma = a[W-1] ? W'(-a) : W'(a);
    mb = b[W-1] ? W'(-b) : W'(b);
    lt = a < b;
    gt = a > b;
    c0.op = in_ch.op;
    c0.neg = a[W-1] ^ b[W-1];
    c0.derr = (in_ch.op == OP_DIV) && (b == '0);
    c0.cmp = 1'b0;
    c0.simple = '0;
    unique case (in_ch.op)
      OP_ADD: c0.simple = a + b;
      OP_SUB: c0.simple = a - b;
      OP_GT: c0.cmp = gt;
      OP_LT: c0.cmp = lt;
      OP_GE: c0.cmp = !lt;
      OP_LE: c0.cmp = !gt;
      OP_EQ: c0.cmp = (a == b);
      OP_NE: c0.cmp = (a != b);
      OP_MIN: c0.simple = lt ? a : b;
      OP_MAX: c0.simple = gt ? a : b;
      OP_INC: c0.simple = a + W'(1);
      OP_DEC: c0.simple = a - W'(1);
      OP_TO_INT: c0.simple = a[W-1] ? W'(-(ma >> FRAC_BITS)) : (ma >> FRAC_BITS);
      OP_FROM_INT: c0.simple = a << FRAC_BITS;
      default: c0.simple = '0;
    endcase
  end

  // pipeline arrays: index k = state after stage k
  logic vld [0:NS];
  ctl_t ctl [0:NS];
  logic [NB-1:0] num [0:NS];
  logic [W:0] rem [0:NS];
  logic [W-1:0] den [0:NS];
  logic [W-1:0] pa, pb;
  logic [PB-1:0] prod [1:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_ch.valid;
    end
    if (adv) begin
      ctl[0] <= c0;
      num[0] <= {ma, {FRAC_BITS{1'b0}}};
      rem[0] <= '0;
      den[0] <= mb;
      pa <= ma;
      pb <= mb;
    end
  end

  // ---- multiply: one stage after operand register ----
  always_ff @(posedge clk) begin
    if (adv) begin
      prod[1] <= pa * pb;
    end
  end

  // ---- divide: one quotient bit per stage ----
  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_div
      logic [NB-1:0] nn;
      logic [W:0] rr;
      fpa_div_stage #(.NB(NB), .DB(W)) u_stage (
        .num_in(num[k]), .rem_in(rem[k]), .den(den[k]),
        .num_out(nn), .rem_out(rr)
      );
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k+1] <= 1'b0;
        end else if (adv) begin
          vld[k+1] <= vld[k];
        end
        if (adv) begin
          ctl[k+1] <= ctl[k];
          num[k+1] <= nn;
          rem[k+1] <= rr;
          den[k+1] <= den[k];
        end
      end
      if (k >= 1) begin : g_pd
        always_ff @(posedge clk) begin
          if (adv) begin
            prod[k+1] <= prod[k];
          end
        end
      end
    end
  endgenerate

  // ---- final: rounding and result select ----
  logic [PB-1:0] pr;
  logic [NB-1:0] q;
  logic [W+1:0] r2;
  logic [W-1:0] mres, dres, fres;
  always_comb begin
    pr = (prod[NS] + (PB'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    mres = ctl[NS].neg ? W'(-pr) : pr[W-1:0];
    r2 = {rem[NS], 1'b0};
    q = num[NS] + ((r2 >= {2'b00, den[NS]}) ? NB'(1) : NB'(0));
    dres = ctl[NS].neg ? W'(-q) : q[W-1:0];
    unique case (ctl[NS].op)
      OP_MUL: fres = mres;
      OP_DIV: fres = ctl[NS].derr ? '0 : dres;
      default: fres = ctl[NS].simple;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= vld[NS];
    end
    if (adv) begin
      out_ch.result_value <= IO_BITS'(signed'(fres));
      out_ch.compare_true <= ctl[NS].cmp;
      out_ch.divide_error <= ctl[NS].derr;
    end
  end

  `FPA_ASSERT_NEXT(a_hold, clk, rst, out_ch.valid && !out_ch.ready, out_ch.valid)
  `FPA_ASSERT_IMPL(a_err_zero, clk, rst, out_ch.valid && out_ch.divide_error, out_ch.result_value == '0)
  `FPA_ASSERT_IMPL(a_flags, clk, rst, out_ch.valid, !(out_ch.compare_true && out_ch.divide_error))
endmodule
`default_nettype wire
